[hw/rtl/cac_pkg.sv]
// Shared types, register codes and constants for the checkerboard alpha compositor.
// Depends on nothing; every other file of the block imports it.
package cac_pkg;

   // palette geometry
   localparam int PAL_DEPTH = 256;
   localparam int PAL_IDX_W = $clog2(PAL_DEPTH);
   localparam int CNT_W     = 9;
   localparam logic [CNT_W-1:0] PAL_LAST = CNT_W'(PAL_DEPTH - 1);

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;
   localparam int CHAN_CNT   = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BYTES_PER_PIXEL = 3'd0,
      CSR_USE_PALETTE     = 3'd1,
      CSR_COLOR_COUNT     = 3'd2,
      CSR_CHECK_SHIFT     = 3'd3,
      CSR_CHECK_LIGHT     = 3'd4,
      CSR_CHECK_DARK      = 3'd5
   } csr_idx_type;

   typedef enum logic {
      OP_PIXEL     = 1'b0,
      OP_PAL_WRITE = 1'b1
   } op_type;

   // source formats (bytes per pixel)
   localparam logic [2:0] FMT_GRAY_ALPHA = 3'd2;
   localparam logic [2:0] FMT_RGB        = 3'd3;
   localparam logic [2:0] FMT_RGBA       = 3'd4;
   localparam logic [7:0] ALPHA_OPAQUE   = 8'd255;

   // reset values of the registers
   localparam logic [2:0]       RST_BYTES_PER_PIXEL = 3'd3;
   localparam logic [CNT_W-1:0] RST_COLOR_COUNT     = 9'd256;
   localparam logic [2:0]       RST_CHECK_SHIFT     = 3'd2;
   localparam logic [7:0]       RST_CHECK_LIGHT     = 8'd153;
   localparam logic [7:0]       RST_CHECK_DARK      = 8'd102;

   typedef struct packed {
      logic       opcode;
      logic [6:0] column;
      logic [6:0] line_number;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [7:0] byte3;
      logic [7:0] palette_slot;
      logic [23:0] palette_rgb;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   typedef struct packed {
      logic [2:0]       bytes_per_pixel;
      logic             use_palette;
      logic [CNT_W-1:0] color_count;
      logic [2:0]       check_shift;
      logic [7:0]       check_light;
      logic [7:0]       check_dark;
   } csr_type;

   // decoded pixel leaving the first stage
   typedef struct packed {
      logic                     sel_pal;
      logic [CHAN_CNT-1:0][7:0] raw;
      logic [CHAN_CNT-1:0][7:0] pal;
      logic [7:0]               alpha;
      logic [7:0]               check;
   } dec_type;

endpackage

[hw/rtl/cac_decode.sv]
// First stage: format decode, checker phase and palette store with registered read.
// Depends on cac_pkg.
module cac_decode (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             req_valid,
   input  cac_pkg::req_type req_data,
   input  cac_pkg::csr_type cfg,
   output logic             dec_valid,
   output cac_pkg::dec_type dec_data
);
   import cac_pkg::*;

   logic [23:0]          pal_mem [PAL_DEPTH];
   logic [23:0]          pal_rd_ff;
   logic                 valid_ff;
   logic                 sel_pal_ff, sel_pal_in;
   logic [CHAN_CNT-1:0][7:0] raw_ff, raw_in;
   logic [7:0]           alpha_ff, alpha_in;
   logic [7:0]           check_ff, check_in;
   logic [CNT_W-1:0]     limit, idx_wide;
   logic [PAL_IDX_W-1:0] rd_idx;
   logic [6:0]           col_sh, line_sh;
   logic                 accept, is_write, is_pixel, fmt_color;

   assign accept   = req_valid && en;
   assign is_write = req_data.opcode == OP_PAL_WRITE;
   assign is_pixel = req_data.opcode == OP_PIXEL;
   assign fmt_color = cfg.bytes_per_pixel == FMT_RGB || cfg.bytes_per_pixel == FMT_RGBA;

   // decode source format into raw channels, alpha and palette select
   always_comb begin
      sel_pal_in = !fmt_color && cfg.use_palette;
      if (fmt_color) begin
         raw_in = {req_data.byte0, req_data.byte1, req_data.byte2};
      end else begin
         raw_in = {req_data.byte0, req_data.byte0, req_data.byte0};
      end
      if (cfg.bytes_per_pixel == FMT_RGBA) begin
         alpha_in = req_data.byte3;
      end else if (cfg.bytes_per_pixel == FMT_GRAY_ALPHA) begin
         alpha_in = req_data.byte1;
      end else begin
         alpha_in = ALPHA_OPAQUE;
      end
   end

   // clamp palette index to color count and store depth
   always_comb begin
      limit    = (cfg.color_count == '0) ? '0 : cfg.color_count - 1'b1;
      idx_wide = ({1'b0, req_data.byte0} < limit) ? {1'b0, req_data.byte0} : limit;
      if (idx_wide > PAL_LAST) begin
         idx_wide = PAL_LAST;
      end
      rd_idx = idx_wide[PAL_IDX_W-1:0];
   end

   // pick checker gray from the phase of column and row
   assign col_sh   = req_data.column >> cfg.check_shift;
   assign line_sh  = req_data.line_number >> cfg.check_shift;
   assign check_in = (col_sh[0] ^ line_sh[0]) ? cfg.check_light : cfg.check_dark;

   // load palette entries from write words
   always_ff @(posedge clock) begin
      if (accept && is_write && {1'b0, req_data.palette_slot} <= PAL_LAST) begin
         pal_mem[req_data.palette_slot[PAL_IDX_W-1:0]] <= req_data.palette_rgb;
      end
   end

   // registered palette read, held while stalled
   always_ff @(posedge clock) begin
      if (en) begin
         pal_rd_ff <= pal_mem[rd_idx];
      end
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= req_valid && is_pixel;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         sel_pal_ff <= sel_pal_in;
         raw_ff     <= raw_in;
         alpha_ff   <= alpha_in;
         check_ff   <= check_in;
      end
   end

   assign dec_valid        = valid_ff;
   assign dec_data.sel_pal = sel_pal_ff;
   assign dec_data.raw     = raw_ff;
   assign dec_data.pal     = pal_rd_ff;
   assign dec_data.alpha   = alpha_ff;
   assign dec_data.check   = check_ff;

   // a palette write never enters the pipeline, a pixel always does
   a_write_no_word: assert property (@(posedge clock) disable iff (reset)
      accept && is_write |=> !valid_ff)
      else $error("palette write produced a pipeline word");
   a_pixel_enters: assert property (@(posedge clock) disable iff (reset)
      accept && is_pixel |=> valid_ff)
      else $error("accepted pixel was dropped at decode");

endmodule

[hw/rtl/cac_blend.sv]
// Blend stages: difference, multiply by alpha, divide by 255 and add to checker gray.
// Depends on cac_pkg.
module cac_blend (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             dec_valid,
   input  cac_pkg::dec_type dec_data,
   output logic             out_valid,
   output cac_pkg::rsp_type out_data
);
   import cac_pkg::*;

   // stage 2: magnitude and sign of source minus checker
   logic                     v2_ff;
   logic [CHAN_CNT-1:0][7:0] mag_ff, mag_in;
   logic [CHAN_CNT-1:0]      neg2_ff, neg_in;
   logic [7:0]               alpha2_ff, check2_ff;
   logic [CHAN_CNT-1:0][7:0] src;
   // stage 3: product
   logic                     v3_ff;
   logic [CHAN_CNT-1:0][15:0] prod_ff, prod_in;
   logic [CHAN_CNT-1:0]      neg3_ff;
   logic [7:0]               check3_ff;
   // stage 4: result
   logic                     v4_ff;
   logic [CHAN_CNT-1:0][7:0] res_ff, res_in;
   logic [CHAN_CNT-1:0][16:0] qsum;

   always_comb begin
      src = dec_data.sel_pal ? dec_data.pal : dec_data.raw;
      for (int i = 0; i < CHAN_CNT; i++) begin
         if (src[i] >= dec_data.check) begin
            mag_in[i] = src[i] - dec_data.check;
            neg_in[i] = 1'b0;
         end else begin
            mag_in[i] = dec_data.check - src[i];
            neg_in[i] = 1'b1;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < CHAN_CNT; i++) begin
         prod_in[i] = 16'(mag_ff[i]) * 16'(alpha2_ff);
      end
   end

   // floor(x / 255) as (x + 1 + (x >> 8)) >> 8, exact for 8x8-bit products
   always_comb begin
      for (int i = 0; i < CHAN_CNT; i++) begin
         qsum[i] = 17'(prod_ff[i]) + 17'd1 + 17'(prod_ff[i][15:8]);
         if (neg3_ff[i]) begin
            res_in[i] = check3_ff - qsum[i][15:8];
         end else begin
            res_in[i] = check3_ff + qsum[i][15:8];
         end
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= dec_valid;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // advance payload, hold on stall
   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff    <= mag_in;
         neg2_ff   <= neg_in;
         alpha2_ff <= dec_data.alpha;
         check2_ff <= dec_data.check;
         prod_ff   <= prod_in;
         neg3_ff   <= neg2_ff;
         check3_ff <= check2_ff;
         res_ff    <= res_in;
      end
   end

   assign out_valid      = v4_ff;
   assign out_data.red   = res_ff[2];
   assign out_data.green = res_ff[1];
   assign out_data.blue  = res_ff[0];

   // a stall freezes every stage; an enabled stage hands its word on
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable({v2_ff, v3_ff, v4_ff}) && $stable(res_ff))
      else $error("blend pipeline moved during stall");
   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      en && v3_ff |=> v4_ff)
      else $error("word lost between product and result stage");

endmodule

[hw/rtl/checkerboard_alpha_composite_unit.sv]
// Top level of the checkerboard alpha compositor: registers, pipeline enable, stages.
// Depends on cac_pkg, cac_decode and cac_blend.
//
// Usage:
//   req channel (valid/ready) carries one word per pixel or palette write.
//   A pixel word (opcode 0) is decoded by the format registers, blended over
//   a light/dark checkerboard and gives one word on the rsp channel.
//   A palette write word (opcode 1) loads one palette entry and gives none;
//   a pixel accepted in the next cycle already sees the new entry.
//   Pipeline: four register stages (decode and palette read, difference,
//   8x8 multiply, divide by 255 and add); rsp_valid comes from the last.
//   Throughput: one word per clock while rsp_ready does not stall it, set by
//   the four-stage pipeline with one palette read port per cycle.
//   Stall: rsp_ready low with a result waiting freezes all stages and drops
//   req_ready; no word is lost or repeated.
//   Reset (synchronous): pipeline empty, registers to their defaults; the
//   palette contents are undefined until written.
//   The csr port writes one register per cycle with csr_write_en; write it
//   only while the pipeline is empty.
module checkerboard_alpha_composite_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  cac_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output cac_pkg::rsp_type                   rsp_data,
   input  logic                               csr_write_en,
   input  logic [cac_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cac_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import cac_pkg::*;

   csr_type cfg_ff;
   logic    en;
   logic    dec_valid;
   dec_type dec_data;

   // whole pipeline advances unless a result waits
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bytes_per_pixel <= RST_BYTES_PER_PIXEL;
         cfg_ff.use_palette     <= 1'b0;
         cfg_ff.color_count     <= RST_COLOR_COUNT;
         cfg_ff.check_shift     <= RST_CHECK_SHIFT;
         cfg_ff.check_light     <= RST_CHECK_LIGHT;
         cfg_ff.check_dark      <= RST_CHECK_DARK;
      end else if (csr_write_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_BYTES_PER_PIXEL: cfg_ff.bytes_per_pixel <= csr_wdata[2:0];
            CSR_USE_PALETTE:     cfg_ff.use_palette     <= csr_wdata[0];
            CSR_COLOR_COUNT:     cfg_ff.color_count     <= csr_wdata[CNT_W-1:0];
            CSR_CHECK_SHIFT:     cfg_ff.check_shift     <= csr_wdata[2:0];
            CSR_CHECK_LIGHT:     cfg_ff.check_light     <= csr_wdata[7:0];
            CSR_CHECK_DARK:      cfg_ff.check_dark      <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   cac_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .req_valid (req_valid),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .dec_valid (dec_valid),
      .dec_data  (dec_data)
   );

   cac_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .dec_valid (dec_valid),
      .dec_data  (dec_data),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

[dv/tb_checkerboard_alpha_composite_unit.sv]
// Self-checking testbench for the checkerboard alpha compositor: pixel and palette
// words in on req_, composited RGB words checked on rsp_. Depends on cac_pkg and the
// checkerboard_alpha_composite_unit RTL only.
`timescale 1ns / 100ps

module tb_checkerboard_alpha_composite_unit;
   import cac_pkg::*;

   // indexes past the last register; writes there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam int DRAIN_CYCLES = 8;

   typedef enum logic [1:0] {
      RDY_ALWAYS,
      RDY_COIN,
      RDY_SPARSE,
      RDY_BLOCKS
   } ready_mode_e;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   logic                  req_ready;
   req_type               req_data     = '0;
   logic                  rsp_valid;
   logic                  rsp_ready    = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index    = '0;
   logic [CSR_DATA_W-1:0] csr_wdata    = '0;

   // register copy, palette copy and the colors still owed by the block
   csr_type         cfg;
   logic [23:0]     palette_mirror [PAL_DEPTH];
   bit              palette_loaded [PAL_DEPTH];
   rsp_type         blended_q [$];
   int              error_count = 0;
   int              burst_left  = 0;
   int              ready_tick  = 0;
   ready_mode_e     ready_mode  = RDY_ALWAYS;

   checkerboard_alpha_composite_unit u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // palette slot a pixel reads: clamp to color count minus one, then to the store
   function automatic int pal_index(logic [7:0] index_byte);
      int limit;
      int idx;
      limit = (cfg.color_count == 0) ? 0 : int'(cfg.color_count) - 1;
      idx   = (int'(index_byte) < limit) ? int'(index_byte) : limit;
      if (idx > PAL_DEPTH - 1) idx = PAL_DEPTH - 1;
      return idx;
   endfunction

   function automatic bit reads_palette();
      return cfg.use_palette && cfg.bytes_per_pixel != FMT_RGB &&
             cfg.bytes_per_pixel != FMT_RGBA;
   endfunction

   // c + (v - c) * a / 255, quotient truncated toward zero
   function automatic logic [7:0] mix_channel(logic [7:0] v, logic [7:0] c, logic [7:0] a);
      int diff;
      int quot;
      diff = int'(v) - int'(c);
      quot = diff * int'(a) / int'(ALPHA_OPAQUE);
      return 8'(int'(c) + quot);
   endfunction

   function automatic rsp_type blend_over_checker(req_type w);
      logic [7:0]  r, g, b, a, shade;
      logic [23:0] entry;
      logic [6:0]  cx, cy;
      rsp_type     o;
      case (cfg.bytes_per_pixel)
         FMT_RGBA: begin
            r = w.byte0; g = w.byte1; b = w.byte2; a = w.byte3;
         end
         FMT_RGB: begin
            r = w.byte0; g = w.byte1; b = w.byte2; a = ALPHA_OPAQUE;
         end
         default: begin
            if (cfg.use_palette) begin
               entry = palette_mirror[pal_index(w.byte0)];
               r = entry[23:16]; g = entry[15:8]; b = entry[7:0];
            end else begin
               r = w.byte0; g = w.byte0; b = w.byte0;
            end
            a = (cfg.bytes_per_pixel == FMT_GRAY_ALPHA) ? w.byte1 : ALPHA_OPAQUE;
         end
      endcase
      cx    = w.column >> cfg.check_shift;
      cy    = w.line_number >> cfg.check_shift;
      shade = (cx[0] ^ cy[0]) ? cfg.check_light : cfg.check_dark;
      o.red   = mix_channel(r, shade, a);
      o.green = mix_channel(g, shade, a);
      o.blue  = mix_channel(b, shade, a);
      return o;
   endfunction

   // check each delivered color against the oldest one owed, and drive the stall pattern
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (blended_q.size() == 0) begin
            $error("unexpected color word %h", rsp_data);
            error_count++;
         end else begin
            want = blended_q.pop_front();
            if (rsp_data.red !== want.red) begin
               $error("red: expected %0d, got %0d", want.red, rsp_data.red);
               error_count++;
            end
            if (rsp_data.green !== want.green) begin
               $error("green: expected %0d, got %0d", want.green, rsp_data.green);
               error_count++;
            end
            if (rsp_data.blue !== want.blue) begin
               $error("blue: expected %0d, got %0d", want.blue, rsp_data.blue);
               error_count++;
            end
         end
      end
      ready_tick <= ready_tick + 1;
      if (ready_tick[6:0] == 7'd0) ready_mode <= ready_mode_e'($urandom_range(0, 3));
      case (ready_mode)
         RDY_ALWAYS: rsp_ready <= 1'b1;
         RDY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         RDY_SPARSE: rsp_ready <= (ready_tick[1:0] == 2'd3);
         default:    rsp_ready <= ready_tick[4];
      endcase
   end

   // hold one word until it is taken, then update the palette copy or owe a color
   task automatic send_word(input req_type w);
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      if (w.opcode == OP_PAL_WRITE) begin
         palette_mirror[w.palette_slot] = w.palette_rgb;
         palette_loaded[w.palette_slot] = 1'b1;
      end else begin
         blended_q.push_back(blend_over_checker(w));
      end
   endtask

   function automatic req_type pixel_word(logic [6:0] col, logic [6:0] row, logic [7:0] b0,
                                          logic [7:0] b1, logic [7:0] b2, logic [7:0] b3);
      req_type w;
      w              = req_type'({$urandom, $urandom, $urandom});
      w.opcode       = OP_PIXEL;
      w.column       = col;
      w.line_number  = row;
      w.byte0        = b0;
      w.byte1        = b1;
      w.byte2        = b2;
      w.byte3        = b3;
      return w;
   endfunction

   function automatic req_type palette_word(logic [7:0] slot, logic [23:0] rgb);
      req_type w;
      w              = req_type'({$urandom, $urandom, $urandom});
      w.opcode       = OP_PAL_WRITE;
      w.palette_slot = slot;
      w.palette_rgb  = rgb;
      return w;
   endfunction

   // load the slot first if this pixel would read an unwritten palette entry
   task automatic send_pixel(input req_type w);
      int idx;
      if (reads_palette()) begin
         idx = pal_index(w.byte0);
         if (!palette_loaded[idx]) send_word(palette_word(8'(idx), 24'($urandom)));
      end
      send_word(w);
   endtask

   task automatic idle_for(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // random bursts with random gaps between most of them; some bursts run long
   task automatic pace_sender();
      burst_left--;
      if (burst_left <= 0) begin
         if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 6));
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
      end
   endtask

   // stop sending and wait until every owed color is out
   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (blended_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      case (idx)
         CSR_BYTES_PER_PIXEL: cfg.bytes_per_pixel = value[2:0];
         CSR_USE_PALETTE:     cfg.use_palette     = value[0];
         CSR_COLOR_COUNT:     cfg.color_count     = value;
         CSR_CHECK_SHIFT:     cfg.check_shift     = value[2:0];
         CSR_CHECK_LIGHT:     cfg.check_light     = value[7:0];
         CSR_CHECK_DARK:      cfg.check_dark      = value[7:0];
         default: ;
      endcase
   endtask

   task automatic set_format(input int bpp, input int pal, input int colors,
                             input int shift, input int light, input int dark);
      drain_pipe();
      write_csr(CSR_BYTES_PER_PIXEL, 9'(bpp));
      write_csr(CSR_USE_PALETTE,     9'(pal));
      write_csr(CSR_COLOR_COUNT,     9'(colors));
      write_csr(CSR_CHECK_SHIFT,     9'(shift));
      write_csr(CSR_CHECK_LIGHT,     9'(light));
      write_csr(CSR_CHECK_DARK,      9'(dark));
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // register defaults straight out of reset, corners of the image and the bytes
   task automatic test_reset_defaults();
      send_word(pixel_word(7'd0,   7'd0,   8'd0,   8'd0,   8'd0,   8'd0));
      send_word(pixel_word(7'd127, 7'd127, 8'd255, 8'd255, 8'd255, 8'd255));
      send_word(pixel_word(7'd4,   7'd0,   8'd10,  8'd200, 8'd99,  8'd0));
      send_word(pixel_word(7'd3,   7'd4,   8'd255, 8'd0,   8'd128, 8'd77));
      drain_pipe();
   endtask

   // palette load, index clamping, zero and oversized color counts, gray with alpha
   task automatic test_palette_lookup();
      set_format(1, 1, 4, 2, 255, 0);
      send_word(palette_word(8'd0,   24'h000000));
      send_word(palette_word(8'd1,   24'hFFFFFF));
      send_word(palette_word(8'd2,   24'h123456));
      send_word(palette_word(8'd3,   24'hA5C3E1));
      send_word(palette_word(8'd255, 24'h5A3C1E));
      send_word(pixel_word(7'd0,  7'd0,  8'd0,   8'd0, 8'd0, 8'd0));
      send_word(pixel_word(7'd5,  7'd0,  8'd1,   8'd0, 8'd0, 8'd0));
      send_word(pixel_word(7'd9,  7'd31, 8'd200, 8'd0, 8'd0, 8'd0));
      set_format(2, 1, 256, 1, 0, 255);
      send_word(pixel_word(7'd2,   7'd0, 8'd255, 8'd0,   8'd0, 8'd0));
      send_word(pixel_word(7'd127, 7'd1, 8'd255, 8'd128, 8'd0, 8'd0));
      set_format(1, 1, 0, 3, 200, 40);
      send_word(pixel_word(7'd8, 7'd0, 8'd200, 8'd0, 8'd0, 8'd0));
      set_format(2, 1, 511, 2, 153, 102);
      send_word(pixel_word(7'd1, 7'd1, 8'd255, 8'd1, 8'd0, 8'd0));
      set_format(2, 0, 256, 2, 153, 102);
      send_word(pixel_word(7'd64, 7'd3, 8'd31, 8'd77, 8'd0, 8'd0));
   endtask

   // RGBA alpha extremes, odd format codes, shifts 0 and 7, writes past the last register
   task automatic test_formats();
      set_format(4, 0, 256, 0, 255, 0);
      send_word(pixel_word(7'd1, 7'd0, 8'd255, 8'd0,   8'd77, 8'd0));
      send_word(pixel_word(7'd0, 7'd0, 8'd255, 8'd0,   8'd77, 8'd255));
      send_word(pixel_word(7'd1, 7'd1, 8'd0,   8'd255, 8'd3,  8'd1));
      set_format(0, 0, 256, 7, 0, 255);
      write_csr(CSR_SPARE_LO, 9'h1FF);
      write_csr(CSR_SPARE_HI, 9'h1FF);
      csr_write_en <= 1'b0;
      @(posedge clock);
      send_word(pixel_word(7'd127, 7'd0, 8'd90, 8'd0, 8'd0, 8'd0));
      set_format(5, 0, 256, 6, 255, 255);
      send_word(pixel_word(7'd64, 7'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      set_format(7, 1, 2, 6, 0, 0);
      send_word(palette_word(8'd1, 24'hC0FFEE));
      send_word(pixel_word(7'd0, 7'd64, 8'd1, 8'd0, 8'd0, 8'd0));
   endtask

   // mostly pixels with a few palette writes, under a new register setting per phase
   task automatic test_random_traffic();
      req_type w;
      int      colors;
      for (int phase = 0; phase < 10; phase++) begin
         if (phase == 0) begin
            set_format(4, 1, 256, 6, 255, 0);
         end else if (phase == 1) begin
            set_format(1, 1, 1, 0, 0, 255);
         end else begin
            case ($urandom_range(0, 3))
               0:       colors = $urandom_range(1, 16);
               1:       colors = 256;
               2:       colors = $urandom_range(0, 511);
               default: colors = $urandom_range(1, 255);
            endcase
            set_format(($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4),
                       $urandom_range(0, 1), colors, $urandom_range(0, 7),
                       $urandom_range(0, 255), $urandom_range(0, 255));
         end
         repeat (200) begin
            w = req_type'({$urandom, $urandom, $urandom});
            if ($urandom_range(0, 99) < 15) begin
               w.opcode = OP_PAL_WRITE;
               send_word(w);
            end else begin
               w.opcode = OP_PIXEL;
               if ($urandom_range(0, 7) == 0) w.byte1 = $urandom_range(0, 1) ? 8'd255 : 8'd0;
               if ($urandom_range(0, 7) == 0) w.byte3 = $urandom_range(0, 1) ? 8'd255 : 8'd0;
               send_pixel(w);
            end
            pace_sender();
         end
      end
   endtask

   initial begin
      cfg.bytes_per_pixel = RST_BYTES_PER_PIXEL;
      cfg.use_palette     = 1'b0;
      cfg.color_count     = RST_COLOR_COUNT;
      cfg.check_shift     = RST_CHECK_SHIFT;
      cfg.check_light     = RST_CHECK_LIGHT;
      cfg.check_dark      = RST_CHECK_DARK;
      foreach (palette_loaded[i]) begin
         palette_loaded[i] = 1'b0;
         palette_mirror[i] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_palette_lookup();
      test_formats();
      test_random_traffic();
      drain_pipe();

      if (error_count == 0) begin
         $display("[checkerboard_alpha_composite_unit] OK");
      end else begin
         $display("[checkerboard_alpha_composite_unit] ERROR");
      end
      $finish;
   end

   // stop a hung run
   initial begin
      #2_000_000;
      $display("[checkerboard_alpha_composite_unit] ERROR");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/cac_pkg.sv
hw/rtl/cac_decode.sv
hw/rtl/cac_blend.sv
hw/rtl/checkerboard_alpha_composite_unit.sv
dv/tb_checkerboard_alpha_composite_unit.sv
